// ----- src/gwr_pkg.sv -----
// shared constants, codes and types for the grid window rotate block
package gwr_pkg;

  localparam int MAX_ROWS   = 16;
  localparam int MAX_COLS   = 16;
  localparam int MAX_WINDOW = 8;

  localparam int CELL_W     = 16;
  localparam int POS_W      = 4;
  localparam int REQ_W      = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 5;

  localparam logic [REQ_W-1:0] REQ_WRITE  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_READ   = 2'd1;
  localparam logic [REQ_W-1:0] REQ_ROTATE = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_BOARD_ROWS  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BOARD_COLS  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SIZE = 2'd2;

  localparam logic [4:0] BOARD_ROWS_RST  = 5'd6;
  localparam logic [4:0] BOARD_COLS_RST  = 5'd8;
  localparam logic [3:0] WINDOW_SIZE_RST = 4'd3;

  typedef struct packed {
    logic [4:0] board_rows;
    logic [4:0] board_cols;
    logic [3:0] window_size;
  } cfg_t;

endpackage

// ----- src/gwr_if.sv -----
// request and response channel interfaces
interface gwr_req_if;
  logic                       valid;
  logic                       ready;
  logic [gwr_pkg::REQ_W-1:0]  req_type;
  logic [gwr_pkg::POS_W-1:0]  row;
  logic [gwr_pkg::POS_W-1:0]  col;
  logic [gwr_pkg::CELL_W-1:0] cell_value;
  logic                       direction;

  modport source (output valid, req_type, row, col, cell_value, direction, input ready);
  modport sink (input valid, req_type, row, col, cell_value, direction, output ready);
endinterface

interface gwr_rsp_if;
  logic                       valid;
  logic                       ready;
  logic [gwr_pkg::CELL_W-1:0] read_value;
  logic                       status;

  modport source (output valid, read_value, status, input ready);
  modport sink (input valid, read_value, status, output ready);
endinterface

// ----- src/gwr_ram.sv -----
// generic single-port ram with registered read
module gwr_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ----- src/gwr_seq.sv -----
// request sequencer: bounds checks, rotate copy and write-back, response register
module gwr_seq #(
  parameter int MAX_ROWS   = gwr_pkg::MAX_ROWS,
  parameter int MAX_COLS   = gwr_pkg::MAX_COLS,
  parameter int MAX_WINDOW = gwr_pkg::MAX_WINDOW
) (
  input  logic                                       clk,
  input  logic                                       rst,
  input  gwr_pkg::cfg_t                              cfg,
  gwr_req_if.sink                                    req,
  gwr_rsp_if.source                                  rsp,
  output logic                                       grid_we,
  output logic [$clog2(MAX_ROWS*MAX_COLS)-1:0]       grid_addr,
  output logic [gwr_pkg::CELL_W-1:0]                 grid_wdata,
  input  logic [gwr_pkg::CELL_W-1:0]                 grid_rdata,
  output logic                                       buf_we,
  output logic [$clog2(MAX_WINDOW*MAX_WINDOW)-1:0]   buf_addr,
  output logic [gwr_pkg::CELL_W-1:0]                 buf_wdata,
  input  logic [gwr_pkg::CELL_W-1:0]                 buf_rdata
);

  localparam int RW  = $clog2(MAX_ROWS);
  localparam int CW  = $clog2(MAX_COLS);
  localparam int IW  = $clog2(MAX_WINDOW);
  localparam int GAW = $clog2(MAX_ROWS*MAX_COLS);
  localparam int BAW = $clog2(MAX_WINDOW*MAX_WINDOW);
  localparam int LW  = $clog2(MAX_ROWS + MAX_COLS + 64);

  typedef enum logic [2:0] {
    ST_IDLE, ST_READ, ST_COPY, ST_COPY_END, ST_PUT, ST_PUT_END, ST_FINISH
  } state_t;

  state_t                      state;
  logic [RW-1:0]               top;
  logic [CW-1:0]               left;
  logic                        cw;
  logic [IW-1:0]               dm1;
  logic [IW-1:0]               wi;
  logic [IW-1:0]               wj;
  logic                        cp_pend;
  logic [BAW-1:0]              cp_baddr;
  logic                        pt_pend;
  logic [GAW-1:0]              pt_gaddr;
  logic [gwr_pkg::CELL_W-1:0]  res_value;
  logic                        res_status;

  logic [LW-1:0] rows_use;
  logic [LW-1:0] cols_use;
  logic          in_board;
  logic          d_ok;
  logic          fits;
  logic          accept;
  logic          last;
  logic [IW-1:0] src_r;
  logic [IW-1:0] src_c;

  function automatic logic [GAW-1:0] grid_addr_of(input logic [RW-1:0] r,
                                                  input logic [CW-1:0] c);
    return GAW'(r * MAX_COLS + c);
  endfunction

  function automatic logic [BAW-1:0] buf_addr_of(input logic [IW-1:0] r,
                                                 input logic [IW-1:0] c);
    return BAW'(r * MAX_WINDOW + c);
  endfunction

  assign rows_use = (LW'(cfg.board_rows) > LW'(MAX_ROWS)) ? LW'(MAX_ROWS)
                                                          : LW'(cfg.board_rows);
  assign cols_use = (LW'(cfg.board_cols) > LW'(MAX_COLS)) ? LW'(MAX_COLS)
                                                          : LW'(cfg.board_cols);
  assign in_board = (LW'(req.row) < rows_use) && (LW'(req.col) < cols_use);
  assign d_ok   = (cfg.window_size != '0) && (LW'(cfg.window_size) <= LW'(MAX_WINDOW));
  assign fits   = (LW'(req.row) + LW'(cfg.window_size) <= rows_use) &&
                  (LW'(req.col) + LW'(cfg.window_size) <= cols_use);

  assign req.ready = (state == ST_IDLE);
  assign accept    = req.valid && req.ready;
  assign last      = (wi == dm1) && (wj == dm1);

  // source cell inside the window buffer for the destination (wi, wj)
  assign src_r = cw ? dm1 - wj : wj;
  assign src_c = cw ? wi : dm1 - wi;

  always_comb begin
    grid_we    = 1'b0;
    grid_addr  = grid_addr_of(RW'(req.row), CW'(req.col));
    grid_wdata = req.cell_value;
    if (pt_pend) begin
      grid_we    = 1'b1;
      grid_addr  = pt_gaddr;
      grid_wdata = buf_rdata;
    end else if (state == ST_COPY) begin
      grid_addr = grid_addr_of(top + RW'(wi), left + CW'(wj));
    end else begin
      grid_we = accept && (req.req_type == gwr_pkg::REQ_WRITE) && in_board;
    end
  end

  always_comb begin
    buf_we    = cp_pend;
    buf_wdata = grid_rdata;
    buf_addr  = cp_pend ? cp_baddr : buf_addr_of(src_r, src_c);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      rsp.valid <= 1'b0;
      cp_pend   <= 1'b0;
      pt_pend   <= 1'b0;
    end else begin
      cp_pend <= (state == ST_COPY);
      pt_pend <= (state == ST_PUT);
      if (rsp.valid && rsp.ready && (state != ST_FINISH)) begin
        rsp.valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (req.valid) begin
            res_value  <= '0;
            res_status <= 1'b1;
            state      <= ST_FINISH;
            case (req.req_type)
              gwr_pkg::REQ_WRITE: begin
                res_status <= !in_board;
              end
              gwr_pkg::REQ_READ: begin
                if (in_board) begin
                  state <= ST_READ;
                end
              end
              gwr_pkg::REQ_ROTATE: begin
                if (d_ok && fits) begin
                  top   <= RW'(req.row);
                  left  <= CW'(req.col);
                  cw    <= req.direction;
                  dm1   <= IW'(cfg.window_size - 4'd1);
                  wi    <= '0;
                  wj    <= '0;
                  state <= ST_COPY;
                end
              end
              default: begin
              end
            endcase
          end
        end
        ST_READ: begin
          res_value  <= grid_rdata;
          res_status <= 1'b0;
          state      <= ST_FINISH;
        end
        ST_COPY: begin
          cp_baddr <= buf_addr_of(wi, wj);
          if (wj == dm1) begin
            wj <= '0;
            wi <= wi + IW'(1);
          end else begin
            wj <= wj + IW'(1);
          end
          if (last) begin
            state <= ST_COPY_END;
          end
        end
        ST_COPY_END: begin
          wi    <= '0;
          wj    <= '0;
          state <= ST_PUT;
        end
        ST_PUT: begin
          pt_gaddr <= grid_addr_of(top + RW'(wi), left + CW'(wj));
          if (wj == dm1) begin
            wj <= '0;
            wi <= wi + IW'(1);
          end else begin
            wj <= wj + IW'(1);
          end
          if (last) begin
            state <= ST_PUT_END;
          end
        end
        ST_PUT_END: begin
          res_value  <= '0;
          res_status <= 1'b0;
          state      <= ST_FINISH;
        end
        ST_FINISH: begin
          if (!rsp.valid || rsp.ready) begin
            rsp.valid      <= 1'b1;
            rsp.read_value <= res_value;
            rsp.status     <= res_status;
            state          <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  a_no_pend_overlap: assert property (@(posedge clk) disable iff (rst)
    !(cp_pend && pt_pend))
    else $error("buffer fill and grid write-back pending together");

  a_busy_after_transfer: assert property (@(posedge clk) disable iff (rst)
    accept |=> !req.ready)
    else $error("request taken while previous one still in progress");

  a_idle_no_pend: assert property (@(posedge clk) disable iff (rst)
    req.ready |-> (!cp_pend && !pt_pend))
    else $error("ready while a memory write is outstanding");

  a_rsp_from_finish: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp.valid) |-> $past(state == ST_FINISH))
    else $error("response raised outside finish state");

endmodule

// ----- src/grid_window_rotate_core.sv -----
// top level: configuration registers, grid and window memories, sequencer
// one request at a time; the single-port grid memory takes one cell per cycle
// reset is synchronous: registers go to 6 rows, 8 columns, window 3
// memories are not cleared by reset
module grid_window_rotate_core #(
  parameter int MAX_ROWS   = gwr_pkg::MAX_ROWS,
  parameter int MAX_COLS   = gwr_pkg::MAX_COLS,
  parameter int MAX_WINDOW = gwr_pkg::MAX_WINDOW
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [gwr_pkg::CFG_IDX_W-1:0]    cfg_addr,
  input  logic [gwr_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  gwr_req_if.sink                          req,
  gwr_rsp_if.source                        rsp
);

  localparam int GAW = $clog2(MAX_ROWS*MAX_COLS);
  localparam int BAW = $clog2(MAX_WINDOW*MAX_WINDOW);

  gwr_pkg::cfg_t              cfg;
  logic                       grid_we;
  logic [GAW-1:0]             grid_addr;
  logic [gwr_pkg::CELL_W-1:0] grid_wdata;
  logic [gwr_pkg::CELL_W-1:0] grid_rdata;
  logic                       buf_we;
  logic [BAW-1:0]             buf_addr;
  logic [gwr_pkg::CELL_W-1:0] buf_wdata;
  logic [gwr_pkg::CELL_W-1:0] buf_rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.board_rows  <= gwr_pkg::BOARD_ROWS_RST;
      cfg.board_cols  <= gwr_pkg::BOARD_COLS_RST;
      cfg.window_size <= gwr_pkg::WINDOW_SIZE_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        gwr_pkg::REG_BOARD_ROWS:  cfg.board_rows  <= cfg_wdata[4:0];
        gwr_pkg::REG_BOARD_COLS:  cfg.board_cols  <= cfg_wdata[4:0];
        gwr_pkg::REG_WINDOW_SIZE: cfg.window_size <= cfg_wdata[3:0];
        default: begin
        end
      endcase
    end
  end

  gwr_ram #(
    .WIDTH (gwr_pkg::CELL_W),
    .DEPTH (MAX_ROWS*MAX_COLS)
  ) u_grid_ram (
    .clk   (clk),
    .we    (grid_we),
    .addr  (grid_addr),
    .wdata (grid_wdata),
    .rdata (grid_rdata)
  );

  gwr_ram #(
    .WIDTH (gwr_pkg::CELL_W),
    .DEPTH (MAX_WINDOW*MAX_WINDOW)
  ) u_buf_ram (
    .clk   (clk),
    .we    (buf_we),
    .addr  (buf_addr),
    .wdata (buf_wdata),
    .rdata (buf_rdata)
  );

  gwr_seq #(
    .MAX_ROWS   (MAX_ROWS),
    .MAX_COLS   (MAX_COLS),
    .MAX_WINDOW (MAX_WINDOW)
  ) u_seq (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .req        (req),
    .rsp        (rsp),
    .grid_we    (grid_we),
    .grid_addr  (grid_addr),
    .grid_wdata (grid_wdata),
    .grid_rdata (grid_rdata),
    .buf_we     (buf_we),
    .buf_addr   (buf_addr),
    .buf_wdata  (buf_wdata),
    .buf_rdata  (buf_rdata)
  );

endmodule

// ----- test/grid_window_rotate_core_tb.sv -----
`timescale 1ns / 100ps
// self-checking testbench for grid_window_rotate_core: directed plan, then fixed and random board settings
module grid_window_rotate_core_tb;

  localparam int REQ_W      = gwr_pkg::REQ_W;
  localparam int POS_W      = gwr_pkg::POS_W;
  localparam int CELL_W     = gwr_pkg::CELL_W;
  localparam int CFG_IDX_W  = gwr_pkg::CFG_IDX_W;
  localparam int CFG_DATA_W = gwr_pkg::CFG_DATA_W;
  localparam int MAX_ROWS   = gwr_pkg::MAX_ROWS;
  localparam int MAX_COLS   = gwr_pkg::MAX_COLS;
  localparam int MAX_WINDOW = gwr_pkg::MAX_WINDOW;

  localparam logic [REQ_W-1:0]     REQ_UNKNOWN = 2'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE   = 2'd3;
  localparam int CYCLE_LIMIT = 400000;
  localparam int ITEM_GOAL   = 470;
  localparam int IDLE_PCT    = 12;
  localparam int CALM_PHASE  = 4;

  typedef enum logic {STEP_REQ, STEP_CFG} step_t;

  typedef struct packed {
    step_t                 kind;
    logic [REQ_W-1:0]      req_type;
    logic [POS_W-1:0]      row;
    logic [POS_W-1:0]      col;
    logic [CELL_W-1:0]     cell_value;
    logic                  direction;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  fixed;
    logic [CELL_W-1:0]     fixed_value;
    logic                  fixed_status;
  } plan_row_t;

  typedef struct packed {
    logic [CELL_W-1:0] read_value;
    logic              status;
  } answer_t;

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_addr;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  gwr_req_if req_ch ();
  gwr_rsp_if rsp_ch ();

  grid_window_rotate_core i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .req       (req_ch),
    .rsp       (rsp_ch)
  );

  logic [CELL_W-1:0] cells [MAX_ROWS][MAX_COLS];
  bit                filled [MAX_ROWS][MAX_COLS];
  logic [4:0]        shadow_rows;
  logic [4:0]        shadow_cols;
  logic [3:0]        shadow_win;

  answer_t   answer_q [$];
  answer_t   oldest;
  plan_row_t plan [$];
  int        errors = 0;
  int        checks = 0;
  int        cycles = 0;
  bit        calm;
  int        n_write_ok;
  int        n_read_ok;
  int        n_rotate_ok;
  int        n_rejected;
  int        n_done;
  int        n_sent;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d answers outstanding", cycles, answer_q.size());
      $display("[grid_window_rotate_core] ERROR");
      $finish;
    end
  end

  task automatic note_mismatch(string what);
    $display("mismatch at cycle %0d: %s", cycles, what);
    errors++;
  endtask

  function automatic int rows_used();
    return (shadow_rows > MAX_ROWS) ? MAX_ROWS : int'(shadow_rows);
  endfunction

  function automatic int cols_used();
    return (shadow_cols > MAX_COLS) ? MAX_COLS : int'(shadow_cols);
  endfunction

  function automatic answer_t apply_request(logic [REQ_W-1:0] kind, logic [POS_W-1:0] r,
                                            logic [POS_W-1:0] c, logic [CELL_W-1:0] code,
                                            logic cw);
    answer_t           ans;
    logic [CELL_W-1:0] scratch [MAX_WINDOW][MAX_WINDOW];
    bit                mark [MAX_WINDOW][MAX_WINDOW];
    int                nr, nc, d, top, left, sr, sc;
    bit                fits;
    ans.read_value = '0;
    ans.status = 1'b1;
    nr = rows_used();
    nc = cols_used();
    d = int'(shadow_win);
    top = int'(r);
    left = int'(c);
    fits = (top < nr) && (left < nc);
    case (kind)
      gwr_pkg::REQ_WRITE: begin
        if (fits) begin
          cells[top][left] = code;
          filled[top][left] = 1'b1;
          ans.status = 1'b0;
        end
      end
      gwr_pkg::REQ_READ: begin
        if (fits) begin
          ans.read_value = cells[top][left];
          ans.status = 1'b0;
        end
      end
      gwr_pkg::REQ_ROTATE: begin
        if (d >= 1 && d <= MAX_WINDOW && top + d <= nr && left + d <= nc) begin
          for (int i = 0; i < d; i++) begin
            for (int j = 0; j < d; j++) begin
              scratch[i][j] = cells[top+i][left+j];
              mark[i][j] = filled[top+i][left+j];
            end
          end
          for (int i = 0; i < d; i++) begin
            for (int j = 0; j < d; j++) begin
              sr = cw ? d - 1 - j : j;
              sc = cw ? i : d - 1 - i;
              cells[top+i][left+j] = scratch[sr][sc];
              filled[top+i][left+j] = mark[sr][sc];
            end
          end
          ans.status = 1'b0;
        end
      end
      default: ;
    endcase
    return ans;
  endfunction

  function automatic void plan_req(logic [REQ_W-1:0] kind, logic [POS_W-1:0] r,
                                   logic [POS_W-1:0] c, logic [CELL_W-1:0] v, logic dir,
                                   logic fixed, logic [CELL_W-1:0] fv, logic fs);
    plan_row_t pr;
    pr = '0;
    pr.kind = STEP_REQ;
    pr.req_type = kind;
    pr.row = r;
    pr.col = c;
    pr.cell_value = v;
    pr.direction = dir;
    pr.fixed = fixed;
    pr.fixed_value = fv;
    pr.fixed_status = fs;
    plan.push_back(pr);
  endfunction

  function automatic void plan_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    plan_row_t pr;
    pr = '0;
    pr.kind = STEP_CFG;
    pr.cfg_idx = idx;
    pr.cfg_data = data;
    plan.push_back(pr);
  endfunction

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    case (idx)
      gwr_pkg::REG_BOARD_ROWS:  shadow_rows = data;
      gwr_pkg::REG_BOARD_COLS:  shadow_cols = data;
      gwr_pkg::REG_WINDOW_SIZE: shadow_win = data[3:0];
      default: ;
    endcase
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain();
    if (req_ch.valid) req_ch.valid <= 1'b0;
    while (answer_q.size() != 0) @(posedge clk);
  endtask

  task automatic send_item(logic [REQ_W-1:0] kind, logic [POS_W-1:0] r, logic [POS_W-1:0] c,
                           logic [CELL_W-1:0] v, logic dir, logic fixed, answer_t fixed_ans);
    answer_t ans;
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.req_type <= kind;
    req_ch.row <= r;
    req_ch.col <= c;
    req_ch.cell_value <= v;
    req_ch.direction <= dir;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    ans = apply_request(kind, r, c, v, dir);
    n_sent++;
    if (ans.status) begin
      n_rejected++;
    end else begin
      n_done++;
      case (kind)
        gwr_pkg::REQ_WRITE: n_write_ok++;
        gwr_pkg::REQ_READ:  n_read_ok++;
        default:            n_rotate_ok++;
      endcase
    end
    answer_q.push_back(fixed ? fixed_ans : ans);
  endtask

  // response side: check each transfer, then pick ready for the next edge
  always @(posedge clk) begin
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      checks++;
      if (answer_q.size() == 0) begin
        note_mismatch($sformatf("response with nothing outstanding (value %h status %b)",
                                rsp_ch.read_value, rsp_ch.status));
      end else begin
        oldest = answer_q.pop_front();
        if (rsp_ch.read_value !== oldest.read_value)
          note_mismatch($sformatf("read_value got %h want %h", rsp_ch.read_value,
                                  oldest.read_value));
        if (rsp_ch.status !== oldest.status)
          note_mismatch($sformatf("status got %b want %b", rsp_ch.status, oldest.status));
      end
    end
    rsp_ch.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
  end

  initial begin
    logic [REQ_W-1:0]      kind;
    logic [POS_W-1:0]      r, c;
    logic [CELL_W-1:0]     v;
    logic                  dir;
    logic [CFG_DATA_W-1:0] set_rows, set_cols, set_win;
    int                    phase, per, nr, nc, d, roll;

    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_addr <= '0;
    cfg_wdata <= '0;
    req_ch.valid <= 1'b0;
    req_ch.req_type <= '0;
    req_ch.row <= '0;
    req_ch.col <= '0;
    req_ch.cell_value <= '0;
    req_ch.direction <= 1'b0;
    calm = 1'b0;
    n_write_ok = 0;
    n_read_ok = 0;
    n_rotate_ok = 0;
    n_rejected = 0;
    n_done = 0;
    n_sent = 0;
    shadow_rows = gwr_pkg::BOARD_ROWS_RST;
    shadow_cols = gwr_pkg::BOARD_COLS_RST;
    shadow_win = gwr_pkg::WINDOW_SIZE_RST;
    foreach (filled[i, j]) filled[i][j] = 1'b0;

    // reset board is 6 x 8 with a 3 x 3 window
    plan_req(gwr_pkg::REQ_WRITE,  4'd0,  4'd0,  16'hFFFF, 1'b0, 1'b1, 16'h0000, 1'b0);
    plan_req(gwr_pkg::REQ_WRITE,  4'd5,  4'd7,  16'h0000, 1'b1, 1'b1, 16'h0000, 1'b0);
    plan_req(gwr_pkg::REQ_READ,   4'd0,  4'd0,  16'h0000, 1'b0, 1'b1, 16'hFFFF, 1'b0);
    plan_req(gwr_pkg::REQ_READ,   4'd5,  4'd7,  16'hFFFF, 1'b1, 1'b1, 16'h0000, 1'b0);
    plan_req(gwr_pkg::REQ_WRITE,  4'd6,  4'd0,  16'h1234, 1'b0, 1'b1, 16'h0000, 1'b1);
    plan_req(gwr_pkg::REQ_READ,   4'd0,  4'd8,  16'h0000, 1'b0, 1'b1, 16'h0000, 1'b1);
    plan_req(REQ_UNKNOWN,         4'd0,  4'd0,  16'hFFFF, 1'b1, 1'b1, 16'h0000, 1'b1);
    plan_req(gwr_pkg::REQ_WRITE,  4'd1,  4'd1,  16'h1234, 1'b0, 1'b0, 16'h0000, 1'b0);
    plan_req(gwr_pkg::REQ_WRITE,  4'd1,  4'd3,  16'hABCD, 1'b0, 1'b0, 16'h0000, 1'b0);
    plan_req(gwr_pkg::REQ_WRITE,  4'd3,  4'd1,  16'h5A5A, 1'b0, 1'b0, 16'h0000, 1'b0);
    plan_req(gwr_pkg::REQ_ROTATE, 4'd1,  4'd1,  16'h0000, 1'b1, 1'b0, 16'h0000, 1'b0);
    plan_req(gwr_pkg::REQ_READ,   4'd1,  4'd3,  16'h0000, 1'b0, 1'b0, 16'h0000, 1'b0);
    plan_req(gwr_pkg::REQ_ROTATE, 4'd4,  4'd0,  16'h0000, 1'b1, 1'b1, 16'h0000, 1'b1);
    plan_req(gwr_pkg::REQ_ROTATE, 4'd1,  4'd1,  16'h0000, 1'b0, 1'b0, 16'h0000, 1'b0);
    plan_req(gwr_pkg::REQ_READ,   4'd1,  4'd1,  16'h0000, 1'b0, 1'b0, 16'h0000, 1'b0);
    // one-cell window is a no-op rotate
    plan_cfg(gwr_pkg::REG_WINDOW_SIZE, 5'd1);
    plan_req(gwr_pkg::REQ_ROTATE, 4'd5,  4'd7,  16'h0000, 1'b1, 1'b1, 16'h0000, 1'b0);
    plan_cfg(gwr_pkg::REG_WINDOW_SIZE, 5'd0);
    plan_req(gwr_pkg::REQ_ROTATE, 4'd0,  4'd0,  16'h0000, 1'b1, 1'b1, 16'h0000, 1'b1);
    plan_cfg(gwr_pkg::REG_WINDOW_SIZE, 5'd9);
    plan_req(gwr_pkg::REQ_ROTATE, 4'd0,  4'd0,  16'h0000, 1'b0, 1'b1, 16'h0000, 1'b1);
    // empty board rejects everything
    plan_cfg(gwr_pkg::REG_BOARD_ROWS, 5'd0);
    plan_req(gwr_pkg::REQ_WRITE,  4'd0,  4'd0,  16'h0001, 1'b0, 1'b1, 16'h0000, 1'b1);
    // oversized board clamps to storage, spare register index is ignored
    plan_cfg(gwr_pkg::REG_BOARD_ROWS, 5'd31);
    plan_cfg(gwr_pkg::REG_BOARD_COLS, 5'd31);
    plan_cfg(gwr_pkg::REG_WINDOW_SIZE, 5'd8);
    plan_cfg(REG_SPARE, 5'h1F);
    plan_req(gwr_pkg::REQ_WRITE,  4'd15, 4'd15, 16'hA5A5, 1'b0, 1'b1, 16'h0000, 1'b0);
    plan_req(gwr_pkg::REQ_READ,   4'd15, 4'd15, 16'h0000, 1'b0, 1'b1, 16'hA5A5, 1'b0);
    plan_req(gwr_pkg::REQ_ROTATE, 4'd8,  4'd8,  16'h0000, 1'b1, 1'b1, 16'h0000, 1'b0);
    plan_req(gwr_pkg::REQ_ROTATE, 4'd9,  4'd8,  16'h0000, 1'b0, 1'b1, 16'h0000, 1'b1);
    plan_req(gwr_pkg::REQ_READ,   4'd15, 4'd8,  16'h0000, 1'b0, 1'b0, 16'h0000, 1'b0);
    // upper data bit is dropped by the 4-bit window register
    plan_cfg(gwr_pkg::REG_WINDOW_SIZE, 5'h10);
    plan_req(gwr_pkg::REQ_ROTATE, 4'd0,  4'd0,  16'h0000, 1'b1, 1'b1, 16'h0000, 1'b1);

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[k]) begin
      if (plan[k].kind == STEP_CFG) begin
        drain();
        cfg_write(plan[k].cfg_idx, plan[k].cfg_data);
      end else begin
        send_item(plan[k].req_type, plan[k].row, plan[k].col, plan[k].cell_value,
                  plan[k].direction, plan[k].fixed,
                  answer_t'({plan[k].fixed_value, plan[k].fixed_status}));
      end
    end

    n_sent = 0;
    phase = 0;
    while (n_sent < ITEM_GOAL) begin
      case (phase)
        0: begin set_rows = 5'd6;  set_cols = 5'd8;  set_win = 5'd3;  end
        1: begin set_rows = 5'd1;  set_cols = 5'd1;  set_win = 5'd1;  end
        2: begin set_rows = 5'd16; set_cols = 5'd16; set_win = 5'd8;  end
        3: begin set_rows = 5'd31; set_cols = 5'd31; set_win = 5'd15; end
        4: begin set_rows = 5'd10; set_cols = 5'd12; set_win = 5'd5;  end
        5: begin set_rows = 5'd2;  set_cols = 5'd16; set_win = 5'd2;  end
        6: begin set_rows = 5'd16; set_cols = 5'd2;  set_win = 5'd2;  end
        7: begin set_rows = 5'd0;  set_cols = 5'd5;  set_win = 5'd3;  end
        8: begin set_rows = 5'd16; set_cols = 5'd16; set_win = 5'd24; end
        default: begin
          set_rows = 5'(($urandom_range(9) == 0) ? $urandom_range(17, 31)
                                                   : $urandom_range(1, 16));
          set_cols = 5'(($urandom_range(9) == 0) ? $urandom_range(17, 31)
                                                   : $urandom_range(1, 16));
          set_win = 5'(($urandom_range(9) == 0) ? $urandom_range(0, 31)
                                                  : $urandom_range(1, 8));
        end
      endcase
      // sender holds off until every outstanding answer has arrived
      drain();
      cfg_write(gwr_pkg::REG_BOARD_ROWS, set_rows);
      cfg_write(gwr_pkg::REG_BOARD_COLS, set_cols);
      cfg_write(gwr_pkg::REG_WINDOW_SIZE, set_win);
      calm = (phase == CALM_PHASE);
      nr = rows_used();
      nc = cols_used();
      d = int'(shadow_win);
      per = (nr == 0 || nc == 0) ? 8 : 50;
      for (int k = 0; k < per; k++) begin
        roll = $urandom_range(99);
        v = CELL_W'($urandom_range(0, 65535));
        dir = 1'($urandom_range(0, 1));
        r = POS_W'($urandom_range(0, 15));
        c = POS_W'($urandom_range(0, 15));
        if (roll < 10 || nr == 0 || nc == 0) begin
          kind = REQ_W'($urandom_range(0, 3));
        end else if (roll < 45) begin
          kind = gwr_pkg::REQ_WRITE;
          r = POS_W'($urandom_range(0, nr - 1));
          c = POS_W'($urandom_range(0, nc - 1));
        end else if (roll < 75) begin
          kind = gwr_pkg::REQ_READ;
          r = POS_W'($urandom_range(0, nr - 1));
          c = POS_W'($urandom_range(0, nc - 1));
          for (int t = 0; t < 16 && !filled[r][c]; t++) begin
            r = POS_W'($urandom_range(0, nr - 1));
            c = POS_W'($urandom_range(0, nc - 1));
          end
          if (!filled[r][c]) kind = gwr_pkg::REQ_WRITE;
        end else begin
          kind = gwr_pkg::REQ_ROTATE;
          if (d >= 1 && d <= MAX_WINDOW && d <= nr && d <= nc) begin
            r = POS_W'($urandom_range(0, nr - d));
            c = POS_W'($urandom_range(0, nc - d));
          end
        end
        // never read a cell that holds nothing defined
        if (kind == gwr_pkg::REQ_READ && int'(r) < nr && int'(c) < nc && !filled[r][c])
          kind = REQ_UNKNOWN;
        send_item(kind, r, c, v, dir, 1'b0, answer_t'(0));
      end
      calm = 1'b0;
      phase++;
    end

    drain();
    repeat (16) @(posedge clk);
    $display("ran %0d board settings: %0d writes, %0d reads, %0d rotates done, %0d rejected",
             phase, n_write_ok, n_read_ok, n_rotate_ok, n_rejected);
    $display("%0d requests completed, %0d responses checked, %0d mismatches",
             n_done, checks, errors);
    if (errors == 0) begin
      $display("[grid_window_rotate_core] OK");
    end else begin
      $display("[grid_window_rotate_core] ERROR");
    end
    $finish;
  end

endmodule
